FILE: src/lgc_pkg.sv
// ----------------------------------------------------------------------------
// lgc_pkg: shared types and constants of the ground cell classifier
// Holds the geometry constants, derived datapath widths, register indexes,
// reset values and the state types of the control and arithmetic units.
// ----------------------------------------------------------------------------
package lgc_pkg;

	// Range image geometry and coordinate width.
	localparam int SCAN_ROWS   = 16;
	localparam int MAX_COLUMNS = 4096;
	localparam int COORD_BITS  = 20;

	localparam int ROW_W   = $clog2(SCAN_ROWS);
	localparam int COL_W   = 12;
	localparam int COL_TOP = ((MAX_COLUMNS - 1) < 4095) ? (MAX_COLUMNS - 1) : 4095;
	localparam logic [COL_W-1:0] COL_TOP_C = COL_W'(COL_TOP);
	localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCAN_ROWS - 1);

	// Datapath widths derived from the coordinate width.
	localparam int DW    = COORD_BITS + 1;   // difference vector component
	localparam int MUL_W = DW + 1;           // signed multiplier operand
	localparam int NW    = 2 * DW + 1;       // signed normal component
	localparam int MW    = 2 * DW;           // normal component magnitude
	localparam int SZW   = 4 * DW;           // one squared component
	localparam int LW    = SZW + 2;          // squared normal length
	localparam int SQW   = 32;               // squared slope limit
	localparam int RW    = LW + SQW;         // scaled length
	localparam int LHW   = SZW + SQW;        // scaled squared z component

	// Configuration registers.
	localparam int GR_W   = 4;
	localparam int SL_W   = 16;
	localparam int RISE_W = 19;
	localparam int CFG_W  = 19;
	localparam int CIDX_W = 2;

	typedef enum logic [CIDX_W-1:0] {
		CFG_GROUND_ROWS = 2'd0,
		CFG_SLOPE_LIMIT = 2'd1,
		CFG_RISE_LIMIT  = 2'd2
	} cfg_idx_t;

	localparam logic [GR_W-1:0]   GROUND_ROWS_RST = 4'd8;
	localparam logic [SL_W-1:0]   SLOPE_RST       = 16'd52429;
	localparam logic [SQW-1:0]    SLOPE_SQ_RST    = SQW'(SLOPE_RST) * SQW'(SLOPE_RST);
	localparam logic [RISE_W-1:0] RISE_RST        = 19'd100;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} point_t;

	typedef struct packed {
		logic [GR_W-1:0]   ground_rows;
		logic [SQW-1:0]    slope_sq;
		logic [RISE_W-1:0] rise_limit;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic ground;
	} test_res_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_START, ST_TEST, ST_OWN, ST_PREV, ST_CUR, ST_DONE
	} ctl_state_t;

	typedef enum logic [2:0] {
		U_IDLE, U_CROSS, U_CDRAIN, U_ABS, U_SQ, U_SDRAIN, U_SCALE, U_CMP
	} unit_state_t;

endpackage

FILE: src/lidar_ground_cell_classifier.sv
// ----------------------------------------------------------------------------
// lidar_ground_cell_classifier: ground labelling of a streamed range image
// Flow: a point whose cell is tested has its label ready once the normal
//   test unit is through, a wait set mostly by its 32-step serial scaling;
//   other points skip the test. One item is in work at a time, so the next
//   transfer is taken only once the block is idle again. Frame end then
//   emits the further labels one after another.
// Reset clears marks and positions and loads default configuration.
// ----------------------------------------------------------------------------
module lidar_ground_cell_classifier import lgc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [COORD_BITS-1:0] pos_z,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  is_ground,
	output logic [3:0]            scan_row,
	output logic [COL_W-1:0]      scan_column,
	output logic                  frame_done,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CIDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int GW = (ROW_W > GR_W) ? ROW_W : GR_W;

	ctl_state_t state_q, state_d;

	cfg_t      cfg;
	test_res_t res;
	point_t    p_q, lo_pt, up_pt;
	logic      fe_q, first_q;
	logic [ROW_W-1:0]     row_q, k_q, up_addr;
	logic [COL_W-1:0]     col_q, cur_label;
	logic [SCAN_ROWS-1:0] prev_q, cur_q;
	logic test_en, start, out_free, emit;
	logic emit_g, emit_fd;
	logic [ROW_W-1:0] emit_row;
	logic [COL_W-1:0] emit_col;

	logic             out_valid_q, is_ground_q, frame_done_q;
	logic [3:0]       scan_row_q;
	logic [COL_W-1:0] scan_column_q;

	lgc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Upper neighbor row, held in range on the top row where no cell exists.
	assign up_addr = (row_q == LAST_ROW) ? row_q : row_q + 1'b1;

	lgc_point_mem u_mem (
		.clk     (clk),
		.we      (state_q == ST_READ),
		.waddr   (row_q),
		.wdata   (p_q),
		.raddr_a (row_q),
		.raddr_b (up_addr),
		.rd_a_q  (lo_pt),
		.rd_b_q  (up_pt)
	);

	lgc_normal u_normal (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.lo     (lo_pt),
		.up     (up_pt),
		.rt     (p_q),
		.cfg    (cfg),
		.res    (res)
	);

	// Cell test condition and the label of the column now arriving.
	always_comb begin
		test_en   = !first_q && (GW'(row_q) < GW'(cfg.ground_rows)) && (row_q != LAST_ROW);
		cur_label = first_q ? '0 : ((col_q >= COL_TOP_C) ? COL_TOP_C : col_q + 1'b1);
		out_free  = !out_valid_q || out_ready;
		start     = (state_q == ST_START) && test_en;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_READ;
			ST_READ:  state_d = ST_START;
			ST_START: begin
				if (test_en) state_d = ST_TEST;
				else if (!first_q) state_d = ST_OWN;
				else if (fe_q) state_d = ST_CUR;
				else state_d = ST_DONE;
			end
			ST_TEST:  if (res.done) state_d = ST_OWN;
			ST_OWN: begin
				if (out_free) begin
					if (!fe_q) state_d = ST_DONE;
					else if (row_q == LAST_ROW) state_d = ST_CUR;
					else state_d = ST_PREV;
				end
			end
			ST_PREV:  if (out_free && k_q == LAST_ROW) state_d = ST_CUR;
			ST_CUR:   if (out_free && k_q == row_q) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake and label selection.
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		emit     = 1'b0;
		emit_g   = 1'b0;
		emit_row = k_q;
		emit_col = col_q;
		emit_fd  = 1'b0;
		case (state_q)
			ST_OWN: begin
				emit     = out_free;
				emit_g   = prev_q[row_q];
				emit_row = row_q;
			end
			ST_PREV: begin
				emit   = out_free;
				emit_g = prev_q[k_q];
			end
			ST_CUR: begin
				emit     = out_free;
				emit_g   = cur_q[k_q];
				emit_col = cur_label;
				emit_fd  = (k_q == row_q);
			end
			default: ;
		endcase
	end

	// Control state: positions, marks and the label counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			first_q <= 1'b1;
			prev_q  <= '0;
			cur_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_START) begin
				k_q <= '0;
			end
			if (state_q == ST_OWN && out_free) begin
				k_q <= (row_q == LAST_ROW) ? '0 : row_q + 1'b1;
			end
			if (state_q == ST_PREV && out_free) begin
				k_q <= (k_q == LAST_ROW) ? '0 : k_q + 1'b1;
			end
			if (state_q == ST_CUR && out_free) begin
				k_q <= k_q + 1'b1;
			end
			// A ground cell marks its lower, upper and right points.
			if (state_q == ST_TEST && res.done && res.ground) begin
				prev_q[row_q]   <= 1'b1;
				prev_q[up_addr] <= 1'b1;
				cur_q[row_q]    <= 1'b1;
			end
			if (state_q == ST_DONE) begin
				if (fe_q) begin
					prev_q  <= '0;
					cur_q   <= '0;
					row_q   <= '0;
					col_q   <= '0;
					first_q <= 1'b1;
				end else if (row_q == LAST_ROW) begin
					col_q   <= cur_label;
					prev_q  <= cur_q;
					cur_q   <= '0;
					first_q <= 1'b0;
					row_q   <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
		end
	end

	// Input item capture.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			p_q.x <= pos_x;
			p_q.y <= pos_y;
			p_q.z <= pos_z;
			fe_q  <= frame_end;
		end
	end

	// Output register: a label waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			is_ground_q   <= emit_g;
			scan_row_q    <= 4'(emit_row);
			scan_column_q <= emit_col;
			frame_done_q  <= emit_fd;
		end
	end

	assign out_valid   = out_valid_q;
	assign is_ground   = is_ground_q;
	assign scan_row    = scan_row_q;
	assign scan_column = scan_column_q;
	assign frame_done  = frame_done_q;

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && fe_q) |=> (first_q && row_q == '0))
		else $error("frame end did not return to the first column");
	a_first_no_marks: assert property (@(posedge clk) disable iff (!arst_n)
		first_q |-> (cur_q == '0))
		else $error("point marked in the first column");
	a_test_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> !first_q)
		else $error("cell tested without a previous column");

endmodule

FILE: src/lgc_cfg.sv
// ----------------------------------------------------------------------------
// lgc_cfg: configuration registers
// Takes register writes and keeps the squared slope limit ready for the
// ground test.
// ----------------------------------------------------------------------------
module lgc_cfg import lgc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output cfg_t              cfg
);

	logic [GR_W-1:0]   ground_rows_q;
	logic [SL_W-1:0]   slope_q;
	logic [SQW-1:0]    slope_sq_q;
	logic [RISE_W-1:0] rise_q;

	// Every write transfer is taken at once.
	assign cfg_ready = 1'b1;

	// Register writes; the squared slope follows in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ground_rows_q <= GROUND_ROWS_RST;
			slope_q       <= SLOPE_RST;
			slope_sq_q    <= SLOPE_SQ_RST;
			rise_q        <= RISE_RST;
		end else begin
			slope_sq_q <= {{(SQW-SL_W){1'b0}}, slope_q} * {{(SQW-SL_W){1'b0}}, slope_q};
			if (cfg_valid) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GROUND_ROWS: ground_rows_q <= cfg_data[GR_W-1:0];
					CFG_SLOPE_LIMIT: slope_q       <= cfg_data[SL_W-1:0];
					CFG_RISE_LIMIT:  rise_q        <= cfg_data[RISE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign cfg.ground_rows = ground_rows_q;
	assign cfg.slope_sq    = slope_sq_q;
	assign cfg.rise_limit  = rise_q;

endmodule

FILE: src/lgc_point_mem.sv
// ----------------------------------------------------------------------------
// lgc_point_mem: last point of every scan row
// One write port and two registered read ports; a read of the entry being
// written returns the old contents.
// ----------------------------------------------------------------------------
module lgc_point_mem import lgc_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [ROW_W-1:0] waddr,
	input  point_t           wdata,
	input  logic [ROW_W-1:0] raddr_a,
	input  logic [ROW_W-1:0] raddr_b,
	output point_t           rd_a_q,
	output point_t           rd_b_q
);

	point_t mem_q [SCAN_ROWS];

	// Read first, then write.
	always_ff @(posedge clk) begin
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

FILE: src/lgc_normal.sv
// ----------------------------------------------------------------------------
// lgc_normal: surface normal slope test of one cell
// Forms the cross product with one shared multiplier, squares the components
// in half-width pieces, scales the length by the squared slope limit with a
// serial shift-add and compares.
// ----------------------------------------------------------------------------
module lgc_normal import lgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  point_t    lo,
	input  point_t    up,
	input  point_t    rt,
	input  cfg_t      cfg,
	output test_res_t res
);

	localparam int RCW = (DW > RISE_W) ? DW : RISE_W;

	unit_state_t state_q, state_d;

	logic signed [DW-1:0] dx_q, dy_q, dz_q, rx_q, ry_q, rz_q;
	logic [1:0] comp_q, part_q;
	logic issue, last_cross, last_sq;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod_s1;
	logic                      op_v_s1, op_sq_s1;
	logic [1:0]                op_comp_s1, op_part_s1;

	logic signed [NW-1:0] nx_q, ny_q, nz_q, prodc;
	logic [MW-1:0]        mx_q, my_q, mz_q, msel;
	logic                 nonzero_q;
	logic [2*DW-1:0]      p2;
	logic [LW-1:0]        term, len_q;
	logic [SZW-1:0]       sz_q;
	logic [RW-1:0]        acc_q;
	logic [4:0]           bit_q;
	logic [DW-1:0]        rabs;
	logic                 rise_ok, slope_ok;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE:   if (start) state_d = U_CROSS;
			U_CROSS:  if (last_cross) state_d = U_CDRAIN;
			U_CDRAIN: state_d = U_ABS;
			U_ABS:    state_d = U_SQ;
			U_SQ:     if (last_sq) state_d = U_SDRAIN;
			U_SDRAIN: state_d = U_SCALE;
			U_SCALE:  if (bit_q == 5'd0) state_d = U_CMP;
			U_CMP:    state_d = U_IDLE;
			default:  state_d = U_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		issue      = (state_q == U_CROSS) || (state_q == U_SQ);
		last_cross = (state_q == U_CROSS) && (comp_q == 2'd2) && (part_q == 2'd1);
		last_sq    = (state_q == U_SQ) && (comp_q == 2'd2) && (part_q == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			comp_q  <= 2'd0;
			part_q  <= 2'd0;
			op_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			op_v_s1 <= issue;
			if (issue) begin
				if (last_cross || last_sq) begin
					comp_q <= 2'd0;
					part_q <= 2'd0;
				end else if ((state_q == U_CROSS && part_q == 2'd1) ||
					(state_q == U_SQ && part_q == 2'd2)) begin
					comp_q <= comp_q + 2'd1;
					part_q <= 2'd0;
				end else begin
					part_q <= part_q + 2'd1;
				end
			end
		end
	end

	// Multiplier operand selection.
	always_comb begin
		case (comp_q)
			2'd0:    msel = mx_q;
			2'd1:    msel = my_q;
			default: msel = mz_q;
		endcase
		mul_a = '0;
		mul_b = '0;
		if (state_q == U_CROSS) begin
			case ({comp_q, part_q})
				4'b0000: begin mul_a = MUL_W'(dy_q); mul_b = MUL_W'(rz_q); end
				4'b0001: begin mul_a = MUL_W'(dz_q); mul_b = MUL_W'(ry_q); end
				4'b0100: begin mul_a = MUL_W'(dz_q); mul_b = MUL_W'(rx_q); end
				4'b0101: begin mul_a = MUL_W'(dx_q); mul_b = MUL_W'(rz_q); end
				4'b1000: begin mul_a = MUL_W'(dx_q); mul_b = MUL_W'(ry_q); end
				default: begin mul_a = MUL_W'(dy_q); mul_b = MUL_W'(rx_q); end
			endcase
		end else begin
			case (part_q)
				2'd0: begin
					mul_a = $signed({1'b0, msel[MW-1:DW]});
					mul_b = $signed({1'b0, msel[MW-1:DW]});
				end
				2'd1: begin
					mul_a = $signed({1'b0, msel[MW-1:DW]});
					mul_b = $signed({1'b0, msel[DW-1:0]});
				end
				default: begin
					mul_a = $signed({1'b0, msel[DW-1:0]});
					mul_b = $signed({1'b0, msel[DW-1:0]});
				end
			endcase
		end
	end

	// Accumulation terms from the registered product.
	always_comb begin
		prodc = NW'($signed(prod_s1[2*DW-1:0]));
		p2    = prod_s1[2*DW-1:0];
		case (op_part_s1)
			2'd0:    term = LW'(p2) << (2 * DW);
			2'd1:    term = LW'(p2) << (DW + 1);
			default: term = LW'(p2);
		endcase
	end

	// Final checks: rise bound and the scaled slope comparison.
	always_comb begin
		rabs     = rz_q[DW-1] ? DW'(-rz_q) : DW'(rz_q);
		rise_ok  = RCW'(rabs) < RCW'(cfg.rise_limit);
		slope_ok = {{(RW-LHW){1'b0}}, sz_q, {SQW{1'b0}}} > acc_q;
	end

	assign res.done   = (state_q == U_CMP);
	assign res.ground = (state_q == U_CMP) && nonzero_q && rise_ok && slope_ok;

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_s1    <= mul_a * mul_b;
		op_sq_s1   <= (state_q == U_SQ);
		op_comp_s1 <= comp_q;
		op_part_s1 <= part_q;

		if (state_q == U_IDLE && start) begin
			dx_q <= DW'(up.x) - DW'(lo.x);
			dy_q <= DW'(up.y) - DW'(lo.y);
			dz_q <= DW'(up.z) - DW'(lo.z);
			rx_q <= DW'(rt.x) - DW'(lo.x);
			ry_q <= DW'(rt.y) - DW'(lo.y);
			rz_q <= DW'(rt.z) - DW'(lo.z);
		end

		// Cross product components, then squared length and squared z.
		if (op_v_s1 && !op_sq_s1) begin
			case (op_comp_s1)
				2'd0:    nx_q <= (op_part_s1 == 2'd0) ? prodc : nx_q - prodc;
				2'd1:    ny_q <= (op_part_s1 == 2'd0) ? prodc : ny_q - prodc;
				default: nz_q <= (op_part_s1 == 2'd0) ? prodc : nz_q - prodc;
			endcase
		end
		if (state_q == U_ABS) begin
			mx_q      <= nx_q[NW-1] ? MW'(-nx_q) : MW'(nx_q);
			my_q      <= ny_q[NW-1] ? MW'(-ny_q) : MW'(ny_q);
			mz_q      <= nz_q[NW-1] ? MW'(-nz_q) : MW'(nz_q);
			nonzero_q <= (nx_q != '0) || (ny_q != '0) || (nz_q != '0);
			len_q     <= '0;
			sz_q      <= '0;
		end else if (op_v_s1 && op_sq_s1) begin
			len_q <= len_q + term;
			if (op_comp_s1 == 2'd2) begin
				sz_q <= sz_q + SZW'(term);
			end
		end

		// Serial scaling of the length, most significant limit bit first.
		if (state_q == U_SDRAIN) begin
			acc_q <= '0;
			bit_q <= 5'd31;
		end else if (state_q == U_SCALE) begin
			acc_q <= (acc_q << 1) + (cfg.slope_sq[bit_q] ? RW'(len_q) : '0);
			bit_q <= bit_q - 5'd1;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == U_IDLE))
		else $error("cell test started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> !res.done)
		else $error("test result held for more than one cycle");
	a_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(res.done && res.ground) |-> nonzero_q)
		else $error("zero normal classified as ground");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the ground cell classifier
// Streams range image frames into the block, mostly smooth ground patches
// with random noise and some full-range random frames, under random stalls
// on both channels. A scoreboard predicts every point label and compares
// the labels leaving the block in order. Registers are rewritten between
// phases, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
	import lgc_pkg::*;

	typedef struct {
		bit [COORD_BITS-1:0] x;
		bit [COORD_BITS-1:0] y;
		bit [COORD_BITS-1:0] z;
		bit                  fe;
	} pt_item_t;

	typedef struct {
		bit        g;
		bit [3:0]  row;
		bit [11:0] col;
		bit        done;
	} label_t;

	// Label predictor and store of expected labels.
	class label_board;
		longint    pts[SCAN_ROWS][3];
		bit        prev_m[SCAN_ROWS];
		bit        cur_m[SCAN_ROWS];
		int        row_pos;
		int        col_pos;
		bit        first_col;
		int        g_rows;
		longint    slope;
		longint    rise;
		label_t    expected_labels[$];
		int        errors;
		int        n_checked;
		int        n_ground;

		function new();
			for (int i = 0; i < SCAN_ROWS; i++) begin
				prev_m[i] = 0;
				cur_m[i] = 0;
			end
			row_pos = 0;
			col_pos = 0;
			first_col = 1;
			g_rows = 8;
			slope = 52429;
			rise = 100;
			errors = 0;
			n_checked = 0;
			n_ground = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, int unsigned v);
			case (idx)
				CFG_GROUND_ROWS: g_rows = v & 4'hF;
				CFG_SLOPE_LIMIT: slope = v & 16'hFFFF;
				CFG_RISE_LIMIT: rise = v & 19'h7FFFF;
				default: ;
			endcase
		endfunction

		function longint mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		// Normal angle and rise test for the cell at row r.
		function bit ground_cell(int r, longint px, longint py, longint pz);
			longint dx, dy, dz, rx, ry, rz, nx, ny, nz;
			bit [159:0] sx, sy, sz, lhs, rhs;
			dx = pts[r+1][0] - pts[r][0];
			dy = pts[r+1][1] - pts[r][1];
			dz = pts[r+1][2] - pts[r][2];
			rx = px - pts[r][0];
			ry = py - pts[r][1];
			rz = pz - pts[r][2];
			nx = dy * rz - dz * ry;
			ny = dz * rx - dx * rz;
			nz = dx * ry - dy * rx;
			if (nx == 0 && ny == 0 && nz == 0)
				return 0;
			if (!(mag(rz) < rise))
				return 0;
			sx = 160'(mag(nx)) * 160'(mag(nx));
			sy = 160'(mag(ny)) * 160'(mag(ny));
			sz = 160'(mag(nz)) * 160'(mag(nz));
			lhs = sz << 32;
			rhs = (sx + sy + sz) * 160'(slope * slope);
			return lhs > rhs;
		endfunction

		function void push_label(bit g, int row, int col);
			label_t l;
			l.g = g;
			l.row = row[3:0];
			l.col = col[11:0];
			l.done = 0;
			expected_labels.insert(expected_labels.size(), l);
		endfunction

		// Notes an accepted point and queues the labels it releases.
		function void note_point(pt_item_t it);
			int r, cur_label;
			longint px, py, pz;
			r = row_pos;
			px = longint'($signed(it.x));
			py = longint'($signed(it.y));
			pz = longint'($signed(it.z));
			cur_label = first_col ? 0 : (col_pos >= COL_TOP ? COL_TOP : col_pos + 1);
			if (!first_col) begin
				if (r < g_rows && r + 1 < SCAN_ROWS && ground_cell(r, px, py, pz)) begin
					prev_m[r] = 1;
					prev_m[r+1] = 1;
					cur_m[r] = 1;
				end
				push_label(prev_m[r], r, col_pos);
			end
			pts[r][0] = px;
			pts[r][1] = py;
			pts[r][2] = pz;
			if (it.fe) begin
				if (!first_col)
					for (int k = r + 1; k < SCAN_ROWS; k++)
						push_label(prev_m[k], k, col_pos);
				for (int k = 0; k <= r; k++)
					push_label(cur_m[k], k, cur_label);
				expected_labels[expected_labels.size() - 1].done = 1;
				for (int k = 0; k < SCAN_ROWS; k++) begin
					prev_m[k] = 0;
					cur_m[k] = 0;
				end
				row_pos = 0;
				col_pos = 0;
				first_col = 1;
			end else if (r == SCAN_ROWS - 1) begin
				col_pos = cur_label;
				prev_m = cur_m;
				for (int k = 0; k < SCAN_ROWS; k++)
					cur_m[k] = 0;
				first_col = 0;
				row_pos = 0;
			end else begin
				row_pos = r + 1;
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		// Compares one label leaving the block with the oldest expectation.
		task check_label(label_t got);
			label_t e;
			n_checked++;
			if (got.g)
				n_ground++;
			if (expected_labels.size() == 0) begin
				report($sformatf("unexpected label row %0d col %0d", got.row, got.col));
				return;
			end
			e = expected_labels.pop_front();
			if (got.g != e.g)
				report($sformatf("is_ground %0d, want %0d (row %0d col %0d)",
					got.g, e.g, e.row, e.col));
			if (got.row != e.row)
				report($sformatf("scan_row %0d, want %0d", got.row, e.row));
			if (got.col != e.col)
				report($sformatf("scan_column %0d, want %0d", got.col, e.col));
			if (got.done != e.done)
				report($sformatf("frame_done %0d, want %0d", got.done, e.done));
		endtask
	endclass

	localparam int WATCHDOG_LIMIT = 20000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [COORD_BITS-1:0] pos_z;
	logic                  frame_end;
	logic                  out_valid;
	logic                  out_ready;
	logic                  is_ground;
	logic [3:0]            scan_row;
	logic [COL_W-1:0]      scan_column;
	logic                  frame_done;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CIDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	label_board board = new();
	int         idle_cycles = 0;
	int         out_stall = 0;
	bit         busy_mode = 0;
	int         n_points = 0;
	int         n_frames = 0;

	lidar_ground_cell_classifier DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .frame_end(frame_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_ground(is_ground), .scan_row(scan_row), .scan_column(scan_column),
		.frame_done(frame_done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, a few long ones, none at all in busy stretches.
	function int pick_gap();
		int r;
		if (busy_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Label sink: checks each transfer, then picks the next ready value.
	always @(posedge clk) begin
		label_t got;
		int gap;
		if (out_valid && out_ready) begin
			got.g = is_ground;
			got.row = scan_row;
			got.col = scan_column;
			got.done = frame_done;
			board.check_label(got);
		end
		if ((out_valid && out_ready) || (in_valid && in_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (busy_mode) begin
			out_ready <= 1;
			out_stall <= 0;
		end else if (out_stall > 0) begin
			out_ready <= 0;
			out_stall <= out_stall - 1;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			out_ready <= (gap == 0);
			out_stall <= (gap > 0) ? gap - 1 : 0;
		end
	end

	// Watchdog against a stuck handshake.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d labels pending",
				board.expected_labels.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task send_point(bit [COORD_BITS-1:0] x, bit [COORD_BITS-1:0] y,
			bit [COORD_BITS-1:0] z, bit fe);
		pt_item_t it;
		int gap;
		gap = pick_gap();
		it.x = x;
		it.y = y;
		it.z = z;
		it.fe = fe;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		frame_end <= fe;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_point(it);
		n_points++;
		if (fe)
			n_frames++;
	endtask

	// Waits until every label is back and the block has settled.
	task drain();
		in_valid <= 0;
		while (board.expected_labels.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task write_reg(cfg_idx_t idx, int unsigned v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		board.set_reg(idx, v);
	endtask

	task set_regs(int unsigned gr, int unsigned sl, int unsigned rl);
		write_reg(CFG_GROUND_ROWS, gr);
		write_reg(CFG_SLOPE_LIMIT, sl);
		write_reg(CFG_RISE_LIMIT, rl);
	endtask

	// One frame of a gently sloped ground patch with noise; it may end early.
	task ground_frame(int ncols, bit early);
		longint bx, by, bz, x, y, z;
		int stop_row, nz;
		bx = $urandom_range(0, 4000) - 2000;
		by = $urandom_range(0, 4000) - 2000;
		bz = $urandom_range(0, 2000) - 1000;
		nz = $urandom_range(0, 3) == 0 ? 400 : 80;
		stop_row = early ? $urandom_range(0, SCAN_ROWS - 2) : SCAN_ROWS - 1;
		for (int c = 0; c < ncols; c++)
			for (int r = 0; r < SCAN_ROWS; r++) begin
				x = bx + r * 300 + $urandom_range(0, 40) - 20;
				y = by + c * 60 + $urandom_range(0, 20) - 10;
				z = bz + $urandom_range(0, nz) - nz / 2;
				if (c == ncols - 1 && r == stop_row) begin
					send_point(x, y, z, 1);
					return;
				end
				send_point(x, y, z, 0);
			end
	endtask

	// One frame of full-range random points.
	task noise_frame(int ncols);
		int total, stop_at;
		total = ncols * SCAN_ROWS;
		stop_at = $urandom_range(0, 1) ? total - 1 : $urandom_range(0, total - 1);
		for (int i = 0; i <= stop_at; i++)
			send_point(COORD_BITS'($urandom), COORD_BITS'($urandom),
				COORD_BITS'($urandom), i == stop_at);
	endtask

	initial begin
		bit [COORD_BITS-1:0] mx, mn;
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
		frame_end = 0;
		cfg_valid = 0;
		cfg_index = CFG_GROUND_ROWS;
		cfg_data = 0;
		mx = {1'b0, {(COORD_BITS-1){1'b1}}};
		mn = {1'b1, {(COORD_BITS-1){1'b0}}};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: frame end on the very first point, in mid first column.
		send_point(mx, mn, mx, 1);
		send_point(1, 2, 3, 0);
		send_point(4, 5, 6, 1);
		// Coordinate extremes over two columns, frame end in mid column.
		for (int i = 0; i < SCAN_ROWS + 3; i++)
			send_point(i[0] ? mx : mn, i[1] ? mx : mn, i[2] ? mn : mx,
				i == SCAN_ROWS + 2);
		drain();
		// Zero normals with all ground rows tested and the loosest limits.
		set_regs(15, 0, 19'h7FFFF);
		for (int i = 0; i < 2 * SCAN_ROWS; i++)
			send_point(7, 7, 7, i == 2 * SCAN_ROWS - 1);
		drain();

		// Random phases over several register settings.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(8, 52429, 100);
				1: set_regs(15, 0, 19'h7FFFF);
				2: set_regs(0, 65535, 0);
				3: set_regs(15, 65535, 19'h7FFFF);
				4: set_regs(1, 30000, 1);
				default: set_regs($urandom_range(0, 15), $urandom_range(0, 65535),
					$urandom_range(0, 400));
			endcase
			for (int f = 0; f < 2; f++) begin
				busy_mode = $urandom_range(0, 3) == 0;
				if ($urandom_range(0, 3) == 0)
					noise_frame($urandom_range(1, 2));
				else
					ground_frame($urandom_range(1, 3), $urandom_range(0, 4) == 0);
			end
			busy_mode = 0;
			drain();
		end

		if (board.expected_labels.size() > 0)
			board.report("labels left over at the end");
		$display("covered %0d points in %0d frames, %0d labels checked, %0d ground",
			n_points, n_frames, board.n_checked, board.n_ground);
		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/lgc_pkg.sv
src/lgc_cfg.sv
src/lgc_point_mem.sv
src/lgc_normal.sv
src/lidar_ground_cell_classifier.sv
test/testbench.sv
